FILE: design/cfr_pkg.sv
package cfr_pkg;

    // Default largest frame on the wire: start, length, CRC and one spare byte.
    localparam int MAX_FRAME_DEF  = 64;
    localparam int FRAME_OVERHEAD = 4;

    localparam logic [7:0] CRC_POLY        = 8'h07;
    localparam logic [7:0] CRC_INIT        = 8'h00;
    localparam logic [7:0] CRC_MSB         = 8'h80;
    localparam logic [7:0] START_BYTE_INIT = 8'h02;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN,
        ST_BODY,
        ST_READ,
        ST_SHOW
    } cfr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_len;
        logic take_body;
        logic clear_rd;
        logic rd_en;
        logic next_rd;
    } cfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic len_bad;
        logic body_done;
        logic crc_ok;
        logic last_item;
    } cfr_status_t;

    // One byte through the CRC-8, MSB first, eight shift steps.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00)
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: design/crc8_frame_receiver.sv
// Frame receiver for start / length / body / CRC-8 framed serial streams.
//
// Input channel: one received byte per transaction on rx_byte, with in_valid
// and in_ready. The block hunts for the start byte, takes the length L, stores
// the L body bytes (a command and L-1 data bytes) and checks the CRC-8
// (polynomial 0x07, initial value zero) carried in the byte after the body.
// Bytes are taken back to back; in_ready is high whilst a frame is being taken in.
// Output channel: on a good CRC the frame leaves as a run of transactions on
// out_valid and out_ready, one per data byte (one with data_valid low for a
// frame that has no data), the final one marked by last. A bad CRC or a bad
// length drops the frame without any output.
// Read-out: each result is first read from the frame store into the output
// register (ST_READ) and then held there (ST_SHOW) until it is taken, so the
// next result is not read before the last one has gone. The single read port of the store sets this.
// in_ready stays low until the last result of the run has been taken, so a
// stall on out_ready holds back the input channel too.
// Reset returns the block to hunting and the start byte register to 0x02; it
// may be rewritten through start_byte_we whilst the block is idle.
module crc8_frame_receiver #(
    parameter int MAX_FRAME = cfr_pkg::MAX_FRAME_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start_byte_we,
    input  logic [7:0] start_byte,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] command,
    output logic [7:0] data_byte,
    output logic       data_valid,
    output logic [5:0] byte_index,
    output logic [5:0] payload_length,
    output logic       last
);

    // Commands and status between the controller and the datapath.
    cfr_pkg::cfr_cmd_t    cmd;
    cfr_pkg::cfr_status_t status;

    // The controller sequences hunting, length, body and read-out of the run.
    cfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    // The datapath holds the start byte register, the CRC, the counters and
    // the frame store with its registered read port.
    cfr_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .start_byte_we  (start_byte_we),
        .start_byte     (start_byte),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .command        (command),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .byte_index     (byte_index),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule

FILE: design/cfr_ctrl.sv
module cfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    input  cfr_pkg::cfr_status_t status,
    output cfr_pkg::cfr_cmd_t    cmd,
    output logic                in_ready,
    output logic                out_valid
);

    cfr_pkg::cfr_state_t state_reg;
    cfr_pkg::cfr_state_t state_next;
    logic                in_fire;

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfr_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfr_pkg::ST_HUNT:
            begin
                if (in_fire && status.is_start)
                begin
                    state_next = cfr_pkg::ST_LEN;
                end
            end
            cfr_pkg::ST_LEN:
            begin
                if (in_fire)
                begin
                    state_next = status.len_bad ? cfr_pkg::ST_HUNT : cfr_pkg::ST_BODY;
                end
            end
            cfr_pkg::ST_BODY:
            begin
                if (in_fire && status.body_done)
                begin
                    state_next = status.crc_ok ? cfr_pkg::ST_READ : cfr_pkg::ST_HUNT;
                end
            end
            cfr_pkg::ST_READ:
            begin
                state_next = cfr_pkg::ST_SHOW;
            end
            cfr_pkg::ST_SHOW:
            begin
                if (out_ready)
                begin
                    state_next = status.last_item ? cfr_pkg::ST_HUNT : cfr_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = cfr_pkg::ST_HUNT;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            cfr_pkg::ST_HUNT:
            begin
                in_ready = 1'b1;
            end
            cfr_pkg::ST_LEN:
            begin
                in_ready     = 1'b1;
                cmd.load_len = in_valid && !status.len_bad;
            end
            cfr_pkg::ST_BODY:
            begin
                in_ready      = 1'b1;
                cmd.take_body = in_valid && !status.body_done;
                cmd.clear_rd  = in_valid && status.body_done;
            end
            cfr_pkg::ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            cfr_pkg::ST_SHOW:
            begin
                out_valid   = 1'b1;
                cmd.next_rd = out_ready && !status.last_item;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/cfr_datapath.sv
module cfr_datapath #(
    parameter int MAX_FRAME = cfr_pkg::MAX_FRAME_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start_byte_we,
    input  logic [7:0]           start_byte,
    input  logic [7:0]           rx_byte,
    input  cfr_pkg::cfr_cmd_t    cmd,
    output cfr_pkg::cfr_status_t status,
    output logic [7:0]           command,
    output logic [7:0]           data_byte,
    output logic                 data_valid,
    output logic [5:0]           byte_index,
    output logic [5:0]           payload_length,
    output logic                 last
);

    localparam int STORE_DEPTH = MAX_FRAME - cfr_pkg::FRAME_OVERHEAD;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

    logic [7:0]        start_byte_reg;
    logic [LEN_W-1:0]  frame_len_reg;
    logic [LEN_W-1:0]  byte_count_reg;
    logic [7:0]        crc_reg;
    logic [7:0]        cmd_byte_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        store_mem [STORE_DEPTH];

    logic [LEN_W-1:0]  data_count;
    logic [ADDR_W-1:0] rd_addr;
    logic              has_data;

    assign data_count = frame_len_reg - LEN_W'(1);
    assign rd_addr    = rd_idx_reg + ADDR_W'(1);
    assign has_data   = (data_count != '0);

    assign status.is_start  = (rx_byte == start_byte_reg);
    assign status.len_bad   = (rx_byte == 8'd0) || (rx_byte > 8'(STORE_DEPTH));
    assign status.body_done = (byte_count_reg == frame_len_reg);
    assign status.crc_ok    = (rx_byte == crc_reg);
    assign status.last_item = !has_data || (LEN_W'(rd_idx_reg) == data_count - LEN_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= cfr_pkg::START_BYTE_INIT;
            frame_len_reg  <= '0;
            byte_count_reg <= '0;
            crc_reg        <= cfr_pkg::CRC_INIT;
            rd_idx_reg     <= '0;
        end
        else
        begin
            if (start_byte_we)
            begin
                start_byte_reg <= start_byte;
            end
            if (cmd.load_len)
            begin
                frame_len_reg  <= rx_byte[LEN_W-1:0];
                byte_count_reg <= '0;
                crc_reg        <= cfr_pkg::CRC_INIT;
            end
            else if (cmd.take_body)
            begin
                byte_count_reg <= byte_count_reg + LEN_W'(1);
                crc_reg        <= cfr_pkg::crc8_update(crc_reg, rx_byte);
            end
            if (cmd.clear_rd)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.next_rd)
            begin
                rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
            end
        end
    end

    // The command byte is kept aside so every result of the run can carry it.
    always_ff @(posedge clk)
    begin
        if (cmd.take_body && (byte_count_reg == '0))
        begin
            cmd_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_body)
        begin
            store_mem[byte_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign command        = cmd_byte_reg;
    assign data_valid     = has_data;
    assign data_byte      = has_data ? rd_data_reg : 8'h00;
    assign byte_index     = 6'(rd_idx_reg);
    assign payload_length = 6'(data_count);
    assign last           = status.last_item;

endmodule

FILE: design/cfr_checker.sv
module cfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] command,
    input logic [7:0] data_byte,
    input logic       data_valid,
    input logic [5:0] byte_index,
    input logic [5:0] payload_length,
    input logic       last
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command) && $stable(data_byte)
            && $stable(byte_index) && $stable(last))
        else $error("result changed while stalled");

    // No byte is taken whilst a run is being delivered.
    a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken during an output run");

    // A frame without data gives a single marked result.
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> last && (byte_index == 6'd0)
            && (payload_length == 6'd0) && (data_byte == 8'h00))
        else $error("malformed result for a frame without data");

    // Data positions stay within the frame.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> byte_index < payload_length)
        else $error("byte index beyond payload length");

    // The marked result is the final data byte.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> (last == (byte_index == payload_length - 6'd1)))
        else $error("last marks the wrong result");

endmodule

bind crc8_frame_receiver cfr_checker u_cfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command        (command),
    .data_byte      (data_byte),
    .data_valid     (data_valid),
    .byte_index     (byte_index),
    .payload_length (payload_length),
    .last           (last)
);

FILE: verif/tb.sv
module tb;

    // The store holds the body of one frame: command plus data bytes.
    localparam int STORE_DEPTH   = cfr_pkg::MAX_FRAME_DEF - cfr_pkg::FRAME_OVERHEAD;
    // Percentage of cycles in which either side idles when idling is allowed.
    localparam int IDLE_PERCENT  = 33;
    // Length of the deliberate hold-off on the output channel.
    localparam int HOLD_CYCLES   = 300;
    // Cycles allowed for the block to return to hunting once nothing is expected.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any accepted transaction before the run is declared hung.
    // The longest legitimate quiet stretch is the hold-off above.
    localparam int STALL_LIMIT   = 2000;

    typedef struct {
        logic [7:0] command;
        logic [7:0] data_byte;
        logic       data_valid;
        logic [5:0] byte_index;
        logic [5:0] payload_length;
        logic       last;
    } frame_result_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       start_byte_we = 1'b0;
    logic [7:0] start_byte    = cfr_pkg::START_BYTE_INIT;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte       = 8'h00;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] command;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [5:0] byte_index;
    logic [5:0] payload_length;
    logic       last;

    crc8_frame_receiver #(
        .MAX_FRAME(cfr_pkg::MAX_FRAME_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_byte_we (start_byte_we),
        .start_byte    (start_byte),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command       (command),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .byte_index    (byte_index),
        .payload_length(payload_length),
        .last          (last)
    );

    always #5 clk = ~clk;

    // Bytes waiting to be offered on the input channel, and the frame results
    // that the deframer is still owed, oldest first.
    logic [7:0]    rx_pending[$];
    frame_result_t expected_results[$];

    // Our own copy of the start byte register and of the deframer state.
    logic [7:0]          start_cfg = cfr_pkg::START_BYTE_INIT;
    cfr_pkg::cfr_state_t deframe_phase = cfr_pkg::ST_HUNT;
    int unsigned         body_want = 0;
    int unsigned         body_got = 0;
    logic [7:0]          body_crc = cfr_pkg::CRC_INIT;
    logic [7:0]          body_store[STORE_DEPTH];

    // Run control shared between the stimulus sequence and the two channels.
    bit calm = 1'b0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int results_checked = 0;
    int frames_passed = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // CRC-8 worked bit by bit, most significant bit first: each incoming bit is
    // folded into the top of the register and the polynomial applied on a one.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? cfr_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Advances the deframer by one received byte and queues any frame results
    // that it releases.
    task automatic deframe_byte(input logic [7:0] b);
        frame_result_t r;
        int            n;
        case (deframe_phase)
            cfr_pkg::ST_LEN:
            begin
                // A zero length, or one the store cannot hold, abandons the frame.
                if (b == 8'h00 || b > 8'(STORE_DEPTH))
                begin
                    deframe_phase = cfr_pkg::ST_HUNT;
                end
                else
                begin
                    body_want     = 32'(b);
                    body_got      = 0;
                    body_crc      = cfr_pkg::CRC_INIT;
                    deframe_phase = cfr_pkg::ST_BODY;
                end
            end
            cfr_pkg::ST_BODY:
            begin
                if (body_got < body_want)
                begin
                    body_store[body_got] = b;
                    body_crc = crc8_step(body_crc, b);
                    body_got++;
                end
                else
                begin
                    // This is the CRC byte; a mismatch drops the frame silently.
                    deframe_phase = cfr_pkg::ST_HUNT;
                    if (b == body_crc)
                    begin
                        frames_passed++;
                        n = body_want - 1;
                        r.command = body_store[0];
                        if (n == 0)
                        begin
                            // A command with no data still yields one result.
                            r.data_byte      = 8'h00;
                            r.data_valid     = 1'b0;
                            r.byte_index     = 6'd0;
                            r.payload_length = 6'd0;
                            r.last           = 1'b1;
                            expected_results.push_back(r);
                        end
                        else
                        begin
                            for (int i = 0; i < n; i++)
                            begin
                                r.data_byte      = body_store[i + 1];
                                r.data_valid     = 1'b1;
                                r.byte_index     = 6'(i);
                                r.payload_length = 6'(n);
                                r.last           = (i == n - 1);
                                expected_results.push_back(r);
                            end
                        end
                    end
                end
            end
            default:
            begin
                // Hunting: only the start byte matters here.
                deframe_phase = (b == start_cfg) ? cfr_pkg::ST_LEN : cfr_pkg::ST_HUNT;
            end
        endcase
    endtask

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_error($sformatf("result %0d, %s is 0x%02h, expected 0x%02h",
                                   results_checked, name, got, want));
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    // Queues a whole frame under the current start byte. A fill of -1 gives
    // random body bytes; otherwise every body byte takes the fill value.
    task automatic queue_frame(input int body_len, input bit bad_crc, input int fill);
        logic [7:0] crc;
        logic [7:0] b;
        crc = cfr_pkg::CRC_INIT;
        put_byte(start_cfg);
        put_byte(8'(body_len));
        for (int i = 0; i < body_len; i++)
        begin
            b   = (fill < 0) ? 8'($urandom) : 8'(fill);
            crc = crc8_step(crc, b);
            put_byte(b);
        end
        if (bad_crc)
        begin
            crc ^= 8'($urandom_range(1, 255));
        end
        put_byte(crc);
    endtask

    // A start byte followed by a length that the block must refuse.
    task automatic queue_bad_length(input logic [7:0] len);
        put_byte(start_cfg);
        put_byte(len);
    endtask

    // Mostly well-formed frames with random content, mostly short and now and
    // then long, mixed with corrupted CRCs, refused lengths and line noise.
    task automatic queue_random_traffic(input int n_bytes);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] b;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at)
        begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(1, STORE_DEPTH)
                                            : $urandom_range(1, 8);
            if (pick < 70)
            begin
                queue_frame(len, 1'b0, -1);
            end
            else if (pick < 82)
            begin
                queue_frame(len, 1'b1, -1);
            end
            else if (pick < 90)
            begin
                queue_bad_length($urandom_range(1) ? 8'h00
                                                   : 8'($urandom_range(STORE_DEPTH + 1, 255)));
            end
            else
            begin
                // Noise between frames avoids the start byte, so that the
                // following frame is not swallowed as a body.
                repeat ($urandom_range(1, 3))
                begin
                    do
                    begin
                        b = 8'($urandom);
                    end
                    while (b == start_cfg);
                    put_byte(b);
                end
            end
        end
    endtask

    // The start byte register is written only with the block at rest; the
    // write takes effect at the edge on which the task lowers start_byte_we.
    task automatic set_start_byte(input logic [7:0] v);
        @(posedge clk);
        start_byte_we <= 1'b1;
        start_byte    <= v;
        @(posedge clk);
        start_byte_we <= 1'b0;
        start_cfg = v;
    endtask

    // Waits until every byte has gone in and every result has come out, then
    // gives the block time to settle back into hunting. Sampling on the
    // falling edge sees the channel signals after the rising edge has settled.
    task automatic wait_for_quiet();
        while (rx_pending.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input side: predicts on every accepted transaction, then either holds the
    // current byte, offers the next one or idles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte);
                bytes_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    rx_byte  <= rx_pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks every accepted result against the oldest one owed,
    // and drives out_ready, including the long hold-off on request.
    always @(posedge clk)
    begin : result_monitor
        frame_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_error($sformatf("result with command 0x%02h arrived, none expected",
                                           command));
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("command", command, want.command);
                    check_field("data_byte", data_byte, want.data_byte);
                    check_field("data_valid", 8'(data_valid), 8'(want.data_valid));
                    check_field("byte_index", 8'(byte_index), 8'(want.byte_index));
                    check_field("payload_length", 8'(payload_length),
                                8'(want.payload_length));
                    check_field("last", 8'(last), 8'(want.last));
                end
                results_checked++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Ends the run if neither channel has moved a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset value of the start byte: noise at both
        // byte extremes, a zero length, a length one beyond the store, a frame
        // with no data, an all-ones frame whose length equals the start byte,
        // a corrupted CRC, and the start byte value inside a frame body.
        put_byte(8'hFF);
        put_byte(8'h00);
        queue_bad_length(8'h00);
        queue_bad_length(8'(STORE_DEPTH + 1));
        queue_frame(1, 1'b0, -1);
        queue_frame(2, 1'b0, 8'hFF);
        queue_frame(1, 1'b1, -1);
        queue_frame(3, 1'b0, int'(cfr_pkg::START_BYTE_INIT));
        wait_for_quiet();

        // Start byte at its low extreme, with neither side idling at all and
        // the longest frame the store can take.
        set_start_byte(8'h00);
        calm = 1'b1;
        queue_frame(STORE_DEPTH, 1'b0, -1);
        queue_random_traffic(20);
        wait_for_quiet();
        calm = 1'b0;

        // Start byte at its high extreme. The output side holds off for a long
        // stretch while frames keep arriving, so the block must stall its input.
        // The sender then pauses until every owed result has come out.
        set_start_byte(8'hFF);
        hold_requests++;
        repeat (4) queue_frame($urandom_range(4, 12), 1'b0, -1);
        wait_for_quiet();

        // A random start byte for the bulk of the random traffic.
        set_start_byte(8'($urandom_range(1, 254)));
        queue_random_traffic(60);
        wait_for_quiet();
        repeat (20) @(posedge clk);

        $display("Covered %0d received bytes under start bytes 0x02, 0x00, 0xff and 0x%02h,",
                 bytes_accepted, start_cfg);
        $display("with %0d good frames, %0d results checked, bad CRCs, bad lengths and a stall.",
                 frames_passed, results_checked);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
